>>> rtl/jcce_pkg.sv
// ----------------------------------------------------------------------------
// JTAG cable command engine package
// Result codes and the result bundle that one host item produces.
// ----------------------------------------------------------------------------
`default_nettype none

package jcce_pkg;

  localparam logic       OP_BYTE  = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;

  localparam logic [1:0] KIND_PIN   = 2'd0;
  localparam logic [1:0] KIND_SHIFT = 2'd1;
  localparam logic [1:0] KIND_PKT   = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [7:0] HDR0 = 8'h31;
  localparam logic [7:0] HDR1 = 8'h60;

  // Leading result of an item: pin update, shift byte or flush close
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] shift_out;
    logic       sample_serial;
    logic [6:0] flush_count;
  } main_res_t;

  // Readback packet byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_res_t;

  // Everything one item produces; cnt counts the leading result plus packet bytes
  typedef struct packed {
    logic [5:0]          pins;
    main_res_t           main;
    pkt_res_t [2:0]      pkt;
    logic [2:0]          cnt;
  } bundle_t;

endpackage

`default_nettype wire

>>> rtl/jcce_ctrl.sv
// ----------------------------------------------------------------------------
// JTAG cable command engine: command decode and protocol state
// Decodes one host item against the pin, shift and packet state and builds
// the bundle of results it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module jcce_ctrl #(
  parameter int PACKET_BYTES = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            opcode,
  input  wire logic [7:0]      host_byte,
  input  wire logic [7:0]      response_bits,
  input  wire logic            tdo_level,
  input  wire logic            data_out_level,
  output jcce_pkg::bundle_t    bundle
);
  import jcce_pkg::*;

  localparam int FILL_W = $clog2(PACKET_BYTES);
  localparam int CW     = FILL_W + 1;

  logic [5:0]        pins_r, pins_nxt;
  logic [5:0]        rem_r, rem_nxt;
  logic              serial_r, serial_nxt;
  logic              rb_r, rb_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic              push;
  logic [7:0]        push_data;
  logic              hdr;
  logic [CW-1:0]     base;
  logic [CW-1:0]     inc;
  logic              pkt_last;
  logic [FILL_W+6:0] fill_ext;

  assign hdr      = (fill_r < FILL_W'(2));
  assign base     = hdr ? CW'(2) : {1'b0, fill_r};
  assign inc      = base + CW'(1);
  assign pkt_last = (inc == CW'(PACKET_BYTES));
  assign fill_ext = {7'd0, fill_r};

  always_comb begin
    pins_nxt   = pins_r;
    rem_nxt    = rem_r;
    serial_nxt = serial_r;
    rb_nxt     = rb_r;
    fill_nxt   = fill_r;
    push       = 1'b0;
    push_data  = response_bits;
    bundle     = '0;

    if (opcode == OP_FLUSH) begin
      if (fill_r != '0) begin
        bundle.main.kind        = KIND_FLUSH;
        bundle.main.flush_count = fill_ext[6:0];
        bundle.cnt              = 3'd1;
        fill_nxt                = '0;
      end
    end else if (rem_r != '0) begin
      // byte shift done: TCK low, TDI left at bit 7
      pins_nxt              = {pins_r[5], host_byte[7], pins_r[3:1], 1'b0};
      bundle.main.kind      = KIND_SHIFT;
      bundle.main.shift_out = host_byte;
      bundle.main.sample_serial = serial_r;
      bundle.cnt            = 3'd1;
      push                  = rb_r;
      push_data             = response_bits;
      rem_nxt               = rem_r - 6'd1;
    end else begin
      rb_nxt = host_byte[6];
      if (host_byte[7]) begin
        rem_nxt    = host_byte[5:0];
        serial_nxt = ~pins_r[3];
      end else begin
        pins_nxt         = host_byte[5:0];
        bundle.main.kind = KIND_PIN;
        bundle.cnt       = 3'd1;
        push             = host_byte[6];
        push_data        = {6'd0, data_out_level, tdo_level};
      end
    end

    if (push) begin
      if (hdr) begin
        bundle.pkt[0] = '{data: HDR0, last: 1'b0};
        bundle.pkt[1] = '{data: HDR1, last: 1'b0};
        bundle.pkt[2] = '{data: push_data, last: pkt_last};
        bundle.cnt    = 3'd4;
      end else begin
        bundle.pkt[0] = '{data: push_data, last: pkt_last};
        bundle.cnt    = 3'd2;
      end
      fill_nxt = pkt_last ? '0 : inc[FILL_W-1:0];
    end

    bundle.pins = pins_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r   <= '0;
      rem_r    <= '0;
      serial_r <= 1'b0;
      rb_r     <= 1'b0;
      fill_r   <= '0;
    end else if (accept) begin
      pins_r   <= pins_nxt;
      rem_r    <= rem_nxt;
      serial_r <= serial_nxt;
      rb_r     <= rb_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jcce_drain.sv
// ----------------------------------------------------------------------------
// JTAG cable command engine: result register and sequencer
// Holds the bundle of one item and hands its results out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jcce_drain (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire jcce_pkg::bundle_t bundle,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_kind,
  output logic                   out_pin_tck,
  output logic                   out_pin_tms,
  output logic                   out_pin_nce,
  output logic                   out_pin_ncs,
  output logic                   out_pin_tdi,
  output logic                   out_pin_oe,
  output logic [7:0]             out_shift_out,
  output logic                   out_sample_serial,
  output logic [7:0]             out_packet_byte,
  output logic                   out_packet_last,
  output logic [6:0]             out_flush_count
);
  import jcce_pkg::*;

  bundle_t    bund_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       at_last;
  logic       out_fire;
  logic       load;
  pkt_res_t   cur_pkt;

  assign last_idx = 2'(bund_r.cnt - 3'd1);
  assign at_last  = (idx_r == last_idx);
  assign out_fire = busy_r && out_ready;
  assign in_ready = !busy_r || (out_ready && at_last);
  assign load     = in_valid && in_ready && (bundle.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (out_fire) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle;
    end
  end

  always_comb begin
    unique case (idx_r)
      2'd1:    cur_pkt = bund_r.pkt[0];
      2'd2:    cur_pkt = bund_r.pkt[1];
      2'd3:    cur_pkt = bund_r.pkt[2];
      default: cur_pkt = '0;
    endcase
  end

  assign out_valid   = busy_r;
  assign out_pin_tck = bund_r.pins[0];
  assign out_pin_tms = bund_r.pins[1];
  assign out_pin_nce = bund_r.pins[2];
  assign out_pin_ncs = bund_r.pins[3];
  assign out_pin_tdi = bund_r.pins[4];
  assign out_pin_oe  = bund_r.pins[5];

  always_comb begin
    if (idx_r == 2'd0) begin
      out_kind          = bund_r.main.kind;
      out_shift_out     = bund_r.main.shift_out;
      out_sample_serial = bund_r.main.sample_serial;
      out_flush_count   = bund_r.main.flush_count;
      out_packet_byte   = 8'd0;
      out_packet_last   = 1'b0;
    end else begin
      out_kind          = KIND_PKT;
      out_shift_out     = 8'd0;
      out_sample_serial = 1'b0;
      out_flush_count   = 7'd0;
      out_packet_byte   = cur_pkt.data;
      out_packet_last   = cur_pkt.last;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jtag_cable_command_engine.sv
// ----------------------------------------------------------------------------
// JTAG cable command engine
// Byte-command engine for a JTAG cable: bit-bang pin writes, byte shifts
// and readback packets with a two-byte header.
// ----------------------------------------------------------------------------
//
//   channel  handshake             payload
//   in       in_valid / in_ready   opcode, host_byte, response_bits, levels
//   out      out_valid / out_ready kind, pin levels, shift/packet/flush data
//
// An item is decoded in the cycle it is accepted; its 0 to 4 results leave
// from the result register one per cycle while out_ready is high.
// The next item is taken in the cycle the last result of the previous one
// is taken, set by the single result port.
// Synchronous active-low reset clears pins, shift count and packet fill.
// A stall on out_ready holds the current result and blocks new items.
// ----------------------------------------------------------------------------
`default_nettype none

module jtag_cable_command_engine #(
  parameter int PACKET_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_opcode,
  input  wire logic [7:0] in_host_byte,
  input  wire logic [7:0] in_response_bits,
  input  wire logic       in_tdo_level,
  input  wire logic       in_data_out_level,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic            out_pin_tck,
  output logic            out_pin_tms,
  output logic            out_pin_nce,
  output logic            out_pin_ncs,
  output logic            out_pin_tdi,
  output logic            out_pin_oe,
  output logic [7:0]      out_shift_out,
  output logic            out_sample_serial,
  output logic [7:0]      out_packet_byte,
  output logic            out_packet_last,
  output logic [6:0]      out_flush_count
);
  import jcce_pkg::*;

  bundle_t bundle;
  logic    accept;

  assign accept = in_valid && in_ready;

  jcce_ctrl #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .opcode         (in_opcode),
    .host_byte      (in_host_byte),
    .response_bits  (in_response_bits),
    .tdo_level      (in_tdo_level),
    .data_out_level (in_data_out_level),
    .bundle         (bundle)
  );

  jcce_drain u_drain (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .bundle            (bundle),
    .in_ready          (in_ready),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_pin_tck       (out_pin_tck),
    .out_pin_tms       (out_pin_tms),
    .out_pin_nce       (out_pin_nce),
    .out_pin_ncs       (out_pin_ncs),
    .out_pin_tdi       (out_pin_tdi),
    .out_pin_oe        (out_pin_oe),
    .out_shift_out     (out_shift_out),
    .out_sample_serial (out_sample_serial),
    .out_packet_byte   (out_packet_byte),
    .out_packet_last   (out_packet_last),
    .out_flush_count   (out_flush_count)
  );

endmodule

`default_nettype wire

>>> rtl/jcce_checker.sv
// ----------------------------------------------------------------------------
// JTAG cable command engine port checker
// Watches the result channel of the engine over time.
// ----------------------------------------------------------------------------
`default_nettype none

module jcce_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_shift_out,
  input wire logic       out_sample_serial,
  input wire logic [7:0] out_packet_byte,
  input wire logic       out_packet_last,
  input wire logic [6:0] out_flush_count
);
  import jcce_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_packet_byte))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_pin_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PIN |-> out_shift_out == 8'd0 &&
      !out_sample_serial && out_packet_byte == 8'd0 && !out_packet_last &&
      out_flush_count == 7'd0)
    else $error("pin update carries stray payload");

  a_flush_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FLUSH |-> out_flush_count != 7'd0 &&
      out_packet_byte == 8'd0 && out_shift_out == 8'd0)
    else $error("flush result malformed");

endmodule

bind jtag_cable_command_engine jcce_checker u_jcce_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_shift_out     (out_shift_out),
  .out_sample_serial (out_sample_serial),
  .out_packet_byte   (out_packet_byte),
  .out_packet_last   (out_packet_last),
  .out_flush_count   (out_flush_count)
);

`default_nettype wire
